@@ rtl/core/jse_pkg.sv @@
// Shared types, byte constants and a helper function for the JSON string escaper.
`default_nettype none

package jse_pkg;

    // Input beat as seen on the input channel
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_string;
        logic       last_of_string;
        logic       empty_string;
    } t_in_item;

    // Output beat as seen on the output channel
    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_run;
    } t_out_item;

    // Body forms of one source byte
    typedef enum logic [1:0] {
        K_PLAIN,
        K_PAIR,
        K_UNI,
        K_EMPTY
    } t_kind;

    // Classified item handed from front to back
    typedef struct packed {
        logic       open_q;
        logic       close_q;
        t_kind      kind;
        logic [7:0] code;
    } t_desc;

    localparam logic [7:0] QUOTE_BYTE  = 8'h22;
    localparam logic [7:0] APOS_BYTE   = 8'h27;
    localparam logic [7:0] SLASH_BYTE  = 8'h2F;
    localparam logic [7:0] BSLASH_BYTE = 8'h5C;
    localparam logic [7:0] LT_BYTE     = 8'h3C;
    localparam logic [7:0] GT_BYTE     = 8'h3E;
    localparam logic [7:0] CTL_BS      = 8'h08;
    localparam logic [7:0] CTL_HT      = 8'h09;
    localparam logic [7:0] CTL_LF      = 8'h0A;
    localparam logic [7:0] CTL_VT      = 8'h0B;
    localparam logic [7:0] CTL_FF      = 8'h0C;
    localparam logic [7:0] CTL_CR      = 8'h0D;
    localparam logic [7:0] CH_LOW_B    = 8'h62;
    localparam logic [7:0] CH_LOW_F    = 8'h66;
    localparam logic [7:0] CH_LOW_N    = 8'h6E;
    localparam logic [7:0] CH_LOW_R    = 8'h72;
    localparam logic [7:0] CH_LOW_T    = 8'h74;
    localparam logic [7:0] CH_LOW_U    = 8'h75;
    localparam logic [7:0] CH_LOW_V    = 8'h76;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CTL_LIMIT   = 8'h20;

    // Lowercase hex digit for one nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] res;
        if (nib < 4'd10) begin
            res = 8'h30 + {4'd0, nib};
        end else begin
            res = 8'h57 + {4'd0, nib};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/jse_front.sv @@
// Front end: accepts input beats and classifies each byte into an escape form.
`default_nettype none

module jse_front
    import jse_pkg::*;
(
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_data,
    input  wire logic     i_q_ready,
    output logic          o_push,
    output t_desc         o_desc
);

    assign o_in_ready = i_q_ready;
    assign o_push     = i_in_valid && i_q_ready;

    always_comb begin
        o_desc.open_q  = i_in_data.first_of_string;
        o_desc.close_q = i_in_data.last_of_string;
        o_desc.kind    = K_PLAIN;
        o_desc.code    = i_in_data.data_byte;
        if (i_in_data.empty_string) begin
            o_desc.open_q  = 1'b1;
            o_desc.close_q = 1'b1;
            o_desc.kind    = K_EMPTY;
        end else begin
            case (i_in_data.data_byte)
                QUOTE_BYTE, APOS_BYTE, BSLASH_BYTE, SLASH_BYTE: begin
                    o_desc.kind = K_PAIR;
                end
                CTL_BS: begin
                    o_desc.kind = K_PAIR;
                    o_desc.code = CH_LOW_B;
                end
                CTL_FF: begin
                    o_desc.kind = K_PAIR;
                    o_desc.code = CH_LOW_F;
                end
                CTL_LF: begin
                    o_desc.kind = K_PAIR;
                    o_desc.code = CH_LOW_N;
                end
                CTL_CR: begin
                    o_desc.kind = K_PAIR;
                    o_desc.code = CH_LOW_R;
                end
                CTL_HT: begin
                    o_desc.kind = K_PAIR;
                    o_desc.code = CH_LOW_T;
                end
                CTL_VT: begin
                    o_desc.kind = K_PAIR;
                    o_desc.code = CH_LOW_V;
                end
                LT_BYTE, GT_BYTE: begin
                    o_desc.kind = K_UNI;
                end
                default: begin
                    if (i_in_data.data_byte < CTL_LIMIT) begin
                        o_desc.kind = K_UNI;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/jse_queue.sv @@
// Short descriptor queue between the front end and the output sequencer.
`default_nettype none

module jse_queue
    import jse_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_desc i_desc,
    output logic       o_ready,
    input  wire logic  i_pop,
    output logic       o_head_valid,
    output t_desc      o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_desc         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;

    assign o_ready      = (r_count != CW'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");
    a_push_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("push lost");
`endif

endmodule

`default_nettype wire

@@ rtl/core/jse_back.sv @@
// Output sequencer: expands each descriptor into escaped bytes through one output register.
`default_nettype none

module jse_back
    import jse_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_head_valid,
    input  wire t_desc i_head,
    output logic       o_pop,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output t_out_item  o_out_data
);

    logic [2:0] r_idx;
    logic       r_out_valid;
    t_out_item  r_out;

    logic [2:0] body_len;
    logic [3:0] total_len;
    logic [2:0] body_idx;
    logic       is_last;
    logic       fire;
    logic [7:0] body_byte;
    logic [7:0] cur_byte;

    always_comb begin
        case (i_head.kind)
            K_PLAIN: body_len = 3'd1;
            K_PAIR:  body_len = 3'd2;
            K_UNI:   body_len = 3'd6;
            K_EMPTY: body_len = 3'd0;
            default: body_len = 3'd0;
        endcase
    end

    assign total_len = {1'b0, body_len} + {3'd0, i_head.open_q} + {3'd0, i_head.close_q};
    assign is_last   = ({1'b0, r_idx} == total_len - 4'd1);
    assign body_idx  = r_idx - {2'd0, i_head.open_q};

    always_comb begin
        body_byte = i_head.code;
        case (i_head.kind)
            K_PAIR: begin
                if (body_idx == 3'd0) begin
                    body_byte = BSLASH_BYTE;
                end
            end
            K_UNI: begin
                case (body_idx)
                    3'd0:    body_byte = BSLASH_BYTE;
                    3'd1:    body_byte = CH_LOW_U;
                    3'd2:    body_byte = CH_ZERO;
                    3'd3:    body_byte = CH_ZERO;
                    3'd4:    body_byte = hex_digit(i_head.code[7:4]);
                    default: body_byte = hex_digit(i_head.code[3:0]);
                endcase
            end
            default: body_byte = i_head.code;
        endcase
    end

    always_comb begin
        if (i_head.open_q && r_idx == 3'd0) begin
            cur_byte = QUOTE_BYTE;
        end else if (body_idx < body_len) begin
            cur_byte = body_byte;
        end else begin
            cur_byte = QUOTE_BYTE;
        end
    end

    // Advance when a descriptor is at the head and the output register is free or being drained
    assign fire  = i_head_valid && (!r_out_valid || i_out_ready);
    assign o_pop = fire && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
                r_idx       <= is_last ? 3'd0 : r_idx + 3'd1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out.out_byte   <= cur_byte;
            r_out.end_of_run <= is_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_mid_item_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 3'd0 |-> i_head_valid)
        else $error("head lost in the middle of an item");
    a_pop_marks_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_valid && r_out.end_of_run)
        else $error("item retired without end_of_run beat");
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> {1'b0, r_idx} < total_len)
        else $error("byte index past item length");
`endif

endmodule

`default_nettype wire

@@ rtl/core/json_string_escaper.sv @@
// Path: the first escaped byte of an item passes through the descriptor queue, then the output register.
// Throughput: an item that yields n output bytes (1 to 8) holds the single output register
// until all n are sent; plain bytes stream at one per cycle while i_out_ready stays high;
// escaped bytes stall the input once the descriptor queue (QUEUE_DEPTH entries) fills.
// Reset: synchronous active-low reset empties the queue, the sequencer and the output register.
`default_nettype none

module json_string_escaper
    import jse_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_data
);

    logic  q_ready;
    logic  push;
    t_desc desc;
    logic  pop;
    logic  head_valid;
    t_desc head;

    jse_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_ready  (q_ready),
        .o_push     (push),
        .o_desc     (desc)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_desc       (desc),
        .o_ready      (q_ready),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    jse_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

`default_nettype wire

@@ test/json_string_escaper_test.sv @@
// Self-checking testbench for the JSON string escaper: directed and random strings, random stalls.
module json_string_escaper_test;
    import jse_pkg::*;

    // Holds the escaped bytes still owed by the block, oldest first
    class escape_scoreboard;
        t_out_item   owed_bytes[$];
        int unsigned failures;

        function new();
            failures = 0;
        endfunction

        function void push_byte(logic [7:0] b);
            t_out_item beat;
            beat.out_byte   = b;
            beat.end_of_run = 1'b0;
            owed_bytes.push_back(beat);
        endfunction

        function logic [7:0] hex_char(logic [3:0] nib);
            logic [7:0] res;
            if (nib < 4'd10) begin
                res = CH_ZERO + {4'd0, nib};
            end else begin
                res = 8'h61 + {4'd0, nib} - 8'd10;
            end
            return res;
        endfunction

        function void note_item(t_in_item it);
            logic [7:0] c;
            logic [7:0] letter;
            t_out_item  tail;
            c      = it.data_byte;
            letter = 8'h00;
            if (it.empty_string) begin
                push_byte(QUOTE_BYTE);
                push_byte(QUOTE_BYTE);
            end else begin
                if (it.first_of_string) begin
                    push_byte(QUOTE_BYTE);
                end
                case (c)
                    QUOTE_BYTE, APOS_BYTE, BSLASH_BYTE, SLASH_BYTE: letter = c;
                    CTL_BS: letter = CH_LOW_B;
                    CTL_FF: letter = CH_LOW_F;
                    CTL_LF: letter = CH_LOW_N;
                    CTL_CR: letter = CH_LOW_R;
                    CTL_HT: letter = CH_LOW_T;
                    CTL_VT: letter = CH_LOW_V;
                    default: letter = 8'h00;
                endcase
                if (letter != 8'h00) begin
                    push_byte(BSLASH_BYTE);
                    push_byte(letter);
                end else if (c < CTL_LIMIT || c == LT_BYTE || c == GT_BYTE) begin
                    push_byte(BSLASH_BYTE);
                    push_byte(CH_LOW_U);
                    push_byte(CH_ZERO);
                    push_byte(CH_ZERO);
                    push_byte(hex_char(c[7:4]));
                    push_byte(hex_char(c[3:0]));
                end else begin
                    push_byte(c);
                end
                if (it.last_of_string) begin
                    push_byte(QUOTE_BYTE);
                end
            end
            // mark the final byte of this item
            tail = owed_bytes.pop_back();
            tail.end_of_run = 1'b1;
            owed_bytes.push_back(tail);
        endfunction

        function void check_beat(t_out_item got);
            t_out_item want;
            if (owed_bytes.size() == 0) begin
                $error("unexpected beat: out_byte %h end_of_run %b", got.out_byte, got.end_of_run);
                failures++;
                return;
            end
            want = owed_bytes.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
                failures++;
            end
            if (got.end_of_run !== want.end_of_run) begin
                $error("end_of_run: expected %b, got %b", want.end_of_run, got.end_of_run);
                failures++;
            end
        endfunction
    endclass

    localparam logic [7:0] SPECIALS [14] = '{
        QUOTE_BYTE, APOS_BYTE, SLASH_BYTE, BSLASH_BYTE, LT_BYTE, GT_BYTE, CTL_BS,
        CTL_HT, CTL_LF, CTL_VT, CTL_FF, CTL_CR, 8'h00, 8'h1F
    };

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_data;

    logic              calm;
    escape_scoreboard  board;
    t_in_item          source_items[$];

    json_string_escaper i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    function automatic t_in_item make_item(logic [7:0] b, logic f, logic l, logic e);
        t_in_item it;
        it.data_byte       = b;
        it.first_of_string = f;
        it.last_of_string  = l;
        it.empty_string    = e;
        return it;
    endfunction

    function automatic logic [7:0] pick_char();
        int unsigned r;
        logic [7:0]  c;
        r = $urandom_range(0, 7);
        if (r < 4) begin
            c = 8'($urandom_range(32, 126));
        end else if (r < 6) begin
            c = SPECIALS[$urandom_range(0, 13)];
        end else begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    function automatic void load_directed();
        source_items.push_back(make_item(8'hFF, 1'b1, 1'b1, 1'b1));
        source_items.push_back(make_item(8'h00, 1'b0, 1'b0, 1'b1));
        source_items.push_back(make_item(LT_BYTE, 1'b1, 1'b1, 1'b0));
        source_items.push_back(make_item(8'h00, 1'b1, 1'b1, 1'b0));
        source_items.push_back(make_item(8'h1F, 1'b1, 1'b0, 1'b0));
        source_items.push_back(make_item(8'h80, 1'b0, 1'b1, 1'b0));
        source_items.push_back(make_item(8'hFF, 1'b0, 1'b0, 1'b0));
        source_items.push_back(make_item(QUOTE_BYTE, 1'b1, 1'b0, 1'b0));
        source_items.push_back(make_item(APOS_BYTE, 1'b0, 1'b0, 1'b0));
        source_items.push_back(make_item(BSLASH_BYTE, 1'b0, 1'b0, 1'b0));
        source_items.push_back(make_item(SLASH_BYTE, 1'b0, 1'b1, 1'b0));
        source_items.push_back(make_item(CTL_BS, 1'b1, 1'b0, 1'b0));
        source_items.push_back(make_item(CTL_FF, 1'b0, 1'b0, 1'b0));
        source_items.push_back(make_item(CTL_LF, 1'b0, 1'b0, 1'b0));
        source_items.push_back(make_item(CTL_CR, 1'b0, 1'b0, 1'b0));
        source_items.push_back(make_item(CTL_HT, 1'b0, 1'b0, 1'b0));
        source_items.push_back(make_item(CTL_VT, 1'b0, 1'b1, 1'b0));
        source_items.push_back(make_item(GT_BYTE, 1'b1, 1'b1, 1'b0));
        source_items.push_back(make_item(CTL_LIMIT, 1'b1, 1'b0, 1'b0));
        source_items.push_back(make_item(8'h7F, 1'b0, 1'b0, 1'b0));
        source_items.push_back(make_item(8'h1B, 1'b0, 1'b0, 1'b0));
        source_items.push_back(make_item(8'h61, 1'b0, 1'b1, 1'b0));
    endfunction

    // Mostly well-formed strings; one pick in ten is a single noise item with random flags
    function automatic void load_random();
        int unsigned len;
        int unsigned j;
        while (source_items.size() < 520) begin
            if ($urandom_range(0, 9) == 0) begin
                source_items.push_back(make_item(8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1))));
            end else begin
                len = $urandom_range(0, 12);
                if (len == 0) begin
                    source_items.push_back(make_item(8'($urandom_range(0, 255)),
                        1'b0, 1'b0, 1'b1));
                end
                for (j = 0; j < len; j++) begin
                    source_items.push_back(make_item(pick_char(), j == 0, j == len - 1, 1'b0));
                end
            end
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(64'd8_000_000);
        $display("json_string_escaper_test NOT OK");
        $finish;
    end

    // Sender: drive source bytes, note each accepted beat
    initial begin
        int unsigned gap;
        board    = new();
        i_rst_n  = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        calm     = 1'b0;
        load_directed();
        load_random();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (source_items[k]) begin
            if (k % 64 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            gap = pick_gap();
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            in_valid <= 1'b1;
            in_data  <= source_items[k];
            do @(posedge i_clk); while (!in_ready);
            board.note_item(source_items[k]);
        end
        in_valid <= 1'b0;
        while (board.owed_bytes.size() != 0) @(posedge i_clk);
        // catch any stray beat after the last expected one
        repeat (16) @(posedge i_clk);
        if (board.failures == 0) begin
            $display("json_string_escaper_test OK");
        end else begin
            $display("json_string_escaper_test NOT OK");
        end
        $finish;
    end

    // Receiver: check each accepted beat, then pick the next ready
    initial begin
        int unsigned hold;
        hold      = 0;
        out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_valid && out_ready) begin
                board.check_beat(out_data);
            end
            if (hold != 0) begin
                out_ready <= 1'b0;
                hold--;
            end else begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    hold = pick_gap();
                end
            end
        end
    end

endmodule
